// ===== hw/rtl/cbor_deterministic_encoder_core_defines.svh =====
// Assertion macros for the encoder core.
// CDE_ASSERT_NOW checks the consequent in the same cycle, CDE_ASSERT_NEXT in the cycle after.
`ifndef CBOR_DETERMINISTIC_ENCODER_CORE_DEFINES_SVH
`define CBOR_DETERMINISTIC_ENCODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder check failed");
`define CDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder check failed");
`else
`define CDE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/cde_pkg.sv =====
package cde_pkg;

    localparam int unsigned C_MAX_NEST = 8;
    localparam logic [15:0] C_CAP_RESET = 16'd1024;

    typedef enum logic [3:0] {
        OP_START  = 4'd0,
        OP_UINT   = 4'd1,
        OP_NEGINT = 4'd2,
        OP_INT    = 4'd3,
        OP_BSTR   = 4'd4,
        OP_TSTR   = 4'd5,
        OP_PAYLD  = 4'd6,
        OP_ARRAY  = 4'd7,
        OP_MAP    = 4'd8,
        OP_TAG    = 4'd9,
        OP_BOOL   = 4'd10,
        OP_NULL   = 4'd11,
        OP_UNDEF  = 4'd12,
        OP_SIMPLE = 4'd13,
        OP_FLOAT  = 4'd14,
        OP_DOUBLE = 4'd15
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_NESTING  = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    localparam logic [2:0] MAJ_UINT   = 3'd0;
    localparam logic [2:0] MAJ_NEGINT = 3'd1;
    localparam logic [2:0] MAJ_BSTR   = 3'd2;
    localparam logic [2:0] MAJ_TSTR   = 3'd3;
    localparam logic [2:0] MAJ_ARRAY  = 3'd4;
    localparam logic [2:0] MAJ_MAP    = 3'd5;
    localparam logic [2:0] MAJ_TAG    = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    localparam logic [4:0] AI_MAX_DIRECT = 5'd23;
    localparam logic [4:0] AI_ONE        = 5'd24;
    localparam logic [4:0] AI_TWO        = 5'd25;
    localparam logic [4:0] AI_FOUR       = 5'd26;
    localparam logic [4:0] AI_EIGHT      = 5'd27;
    localparam logic [7:0] HB_FLOAT      = 8'hFA;
    localparam logic [7:0] HB_DOUBLE     = 8'hFB;
    localparam logic [63:0] SV_FALSE     = 64'd20;
    localparam logic [63:0] SV_TRUE      = 64'd21;
    localparam logic [63:0] SV_NULL      = 64'd22;
    localparam logic [63:0] SV_UNDEF     = 64'd23;

    // head byte, argument left-aligned, argument byte count
    typedef struct packed {
        logic [7:0]  hb;
        logic [63:0] arg;
        logic [3:0]  nb;
    } t_head;

    function automatic t_head head_enc(input logic [2:0] maj, input logic [63:0] a);
        t_head h;
        h.hb  = {maj, 5'd0};
        h.arg = '0;
        h.nb  = 4'd0;
        if (a <= 64'({59'd0, AI_MAX_DIRECT})) begin
            h.hb = {maj, a[4:0]};
        end else if (a <= 64'h0000_0000_0000_00FF) begin
            h.hb  = {maj, AI_ONE};
            h.arg = {a[7:0], 56'd0};
            h.nb  = 4'd1;
        end else if (a <= 64'h0000_0000_0000_FFFF) begin
            h.hb  = {maj, AI_TWO};
            h.arg = {a[15:0], 48'd0};
            h.nb  = 4'd2;
        end else if (a <= 64'h0000_0000_FFFF_FFFF) begin
            h.hb  = {maj, AI_FOUR};
            h.arg = {a[31:0], 32'd0};
            h.nb  = 4'd4;
        end else begin
            h.hb  = {maj, AI_EIGHT};
            h.arg = a;
            h.nb  = 4'd8;
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/cde_if.sv =====
interface cde_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [63:0] value;
    logic [7:0]  payload_byte;

    modport source (output valid, output opcode, output value, output payload_byte,
                    input ready);
    modport sink (input valid, input opcode, input value, input payload_byte,
                  output ready);
endinterface

interface cde_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [1:0]  status;
    logic [15:0] encoded_length;
    logic        error_flag;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output status, output encoded_length, output error_flag,
                    input ready);
    modport sink (input valid, input out_byte, input byte_valid, input last,
                  input status, input encoded_length, input error_flag,
                  output ready);
endinterface

// ===== hw/rtl/cbor_deterministic_encoder_core.sv =====
// Channel   Dir  Handshake      Word
// i_in      in   valid/ready    opcode, value, payload_byte (one encode request)
// o_out     out  valid/ready    out_byte, byte_valid, last, status, length, error
// i_cfg     in   write enable   buffer_capacity, 16 bits
//
// An item is accepted in S_IDLE, then S_EMIT issues its result words (1 to 9) in order,
// each one only while the output is not stalled. When the item counts, the container
// walk passes through S_WRD and S_WCHK for each frame it visits, or S_WRD alone when no
// frame is open. The walk reads the frame memory in S_WRD into a register for S_WCHK.
// Reset is synchronous, active low; the frame memory is not cleared.
// A stalled output holds its word; a new item is taken while the last word waits.
`include "cbor_deterministic_encoder_core_defines.svh"

module cbor_deterministic_encoder_core
    import cde_pkg::*;
#(
    parameter int unsigned MAX_NEST = C_MAX_NEST
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    cde_in_if.sink      i_in,
    cde_out_if.source   o_out
);

    localparam int unsigned DW = $clog2(MAX_NEST + 1);
    localparam int unsigned AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    typedef enum logic [1:0] {S_IDLE, S_EMIT, S_WRD, S_WCHK} t_state;

    typedef struct packed {
        logic [63:0] count;
        logic [63:0] done;
    } t_frame;

    t_state      r_state;
    logic [15:0] r_cap;
    logic [15:0] r_off;
    logic        r_sticky;
    logic [DW-1:0] r_depth;
    logic [63:0] r_sbl;

    logic [7:0]  r_hb;
    logic [63:0] r_arg;
    logic [3:0]  r_nb;
    logic [3:0]  r_idx;
    logic [1:0]  r_st;
    logic [15:0] r_len;
    logic        r_err;
    logic        r_cnt;

    logic        r_ovld;
    logic [7:0]  r_obyte;
    logic        r_obv;
    logic        r_olast;
    logic [1:0]  r_ost;
    logic [15:0] r_olen;
    logic        r_oerr;

    t_frame      r_mem [MAX_NEST];
    t_frame      r_rdata;

    // accept-time decode
    t_opcode     op;
    logic [63:0] v;
    t_head       hd;
    logic [2:0]  maj;
    logic [63:0] harg;
    logic        ok1, ok2;
    logic [3:0]  wr_n;
    logic [15:0] n_off;
    logic        n_sticky;
    logic [DW-1:0] n_depth;
    logic [63:0] n_sbl;
    logic [3:0]  n_nb;
    t_status     n_st;
    logic        n_cnt;
    logic        n_push;
    logic        acc;

    // walk
    logic [AW-1:0] top_addr;
    logic [63:0]   done1;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_frame        mem_wdata;
    logic          mem_re;

    assign acc      = i_in.valid && i_in.ready;
    assign op       = t_opcode'(i_in.opcode);
    assign v        = i_in.value;
    assign top_addr = DW'(r_depth - 1'b1) >> 0 == '0 ? '0 : AW'(DW'(r_depth - 1'b1));
    assign done1    = r_rdata.done + 64'd1;

    always_comb begin
        maj  = MAJ_UINT;
        harg = v;
        unique case (op)
            OP_NEGINT: maj = MAJ_NEGINT;
            OP_INT: begin
                maj  = v[63] ? MAJ_NEGINT : MAJ_UINT;
                harg = v[63] ? ~v : v;
            end
            OP_BSTR:   maj = MAJ_BSTR;
            OP_TSTR:   maj = MAJ_TSTR;
            OP_ARRAY:  maj = MAJ_ARRAY;
            OP_MAP:    maj = MAJ_MAP;
            OP_TAG:    maj = MAJ_TAG;
            OP_BOOL: begin
                maj  = MAJ_SIMPLE;
                harg = (v != 64'd0) ? SV_TRUE : SV_FALSE;
            end
            OP_NULL: begin
                maj  = MAJ_SIMPLE;
                harg = SV_NULL;
            end
            OP_UNDEF: begin
                maj  = MAJ_SIMPLE;
                harg = SV_UNDEF;
            end
            OP_SIMPLE: maj = MAJ_SIMPLE;
            default:   maj = MAJ_UINT;
        endcase
        hd = head_enc(maj, harg);
        unique case (op)
            OP_FLOAT:  hd = '{hb: HB_FLOAT, arg: {v[31:0], 32'd0}, nb: 4'd4};
            OP_DOUBLE: hd = '{hb: HB_DOUBLE, arg: v, nb: 4'd8};
            OP_PAYLD:  hd = '{hb: i_in.payload_byte, arg: 64'd0, nb: 4'd0};
            default:   ;
        endcase
    end

    // each chunk must fit whole: head byte first, then the argument
    always_comb begin
        ok1  = !r_sticky && (({1'b0, r_off} + 17'd1) <= {1'b0, r_cap});
        ok2  = (hd.nb == 4'd0)
            || (({1'b0, r_off} + 17'd1 + {13'd0, hd.nb}) <= {1'b0, r_cap});
        wr_n = ok1 ? (ok2 ? (4'd1 + hd.nb) : 4'd1) : 4'd0;
    end

    always_comb begin
        n_off    = r_off;
        n_sticky = r_sticky;
        n_depth  = r_depth;
        n_sbl    = r_sbl;
        n_nb     = 4'd0;
        n_st     = ST_OK;
        n_cnt    = 1'b0;
        n_push   = 1'b0;
        priority if (r_sbl != 64'd0 && op != OP_START && op != OP_PAYLD) begin
            n_st = ST_INVALID;
        end else if (op == OP_START) begin
            n_off    = 16'd0;
            n_sticky = 1'b0;
            n_depth  = '0;
            n_sbl    = 64'd0;
        end else if (op == OP_PAYLD && r_sbl == 64'd0) begin
            n_st = ST_INVALID;
        end else if (op == OP_SIMPLE && (v > 64'd255 || (v >= 64'd24 && v <= 64'd31))) begin
            n_st = ST_INVALID;
        end else if ((op == OP_ARRAY || op == OP_MAP) && r_depth == DW'(MAX_NEST)) begin
            n_sticky = 1'b1;
            n_st     = ST_NESTING;
        end else if (op == OP_MAP && v[63]) begin
            n_sticky = 1'b1;
            n_st     = ST_NESTING;
        end else begin
            n_nb  = wr_n;
            n_off = r_off + {12'd0, wr_n};
            if (!(ok1 && ok2)) begin
                n_sticky = 1'b1;
                n_st     = ST_OVERFLOW;
            end else begin
                unique case (op)
                    OP_BSTR, OP_TSTR: begin
                        if (v == 64'd0) n_cnt = 1'b1;
                        else n_sbl = v;
                    end
                    OP_PAYLD: begin
                        n_sbl = r_sbl - 64'd1;
                        n_cnt = (r_sbl == 64'd1);
                    end
                    OP_ARRAY, OP_MAP: begin
                        if (v == 64'd0) begin
                            n_cnt = 1'b1;
                        end else begin
                            n_push  = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                    OP_TAG:  n_cnt = 1'b0;
                    default: n_cnt = 1'b1;
                endcase
            end
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = top_addr;
        mem_wdata = '{count: r_rdata.count, done: done1};
        mem_re    = (r_state == S_WRD) && (r_depth != '0);
        if (acc && n_push) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r_depth);
            mem_wdata = '{count: (op == OP_MAP) ? {v[62:0], 1'b0} : v, done: 64'd0};
        end else if (r_state == S_WCHK && done1 < r_rdata.count) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[top_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= C_CAP_RESET;
            r_off    <= 16'd0;
            r_sticky <= 1'b0;
            r_depth  <= '0;
            r_sbl    <= 64'd0;
            r_ovld   <= 1'b0;
            r_idx    <= 4'd0;
            r_cnt    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // the emit state always leaves a word standing
            if (o_out.ready && r_state != S_EMIT) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_off    <= n_off;
                        r_sticky <= n_sticky;
                        r_depth  <= n_depth;
                        r_sbl    <= n_sbl;
                        r_hb     <= hd.hb;
                        r_arg    <= hd.arg;
                        r_nb     <= n_nb;
                        r_idx    <= 4'd0;
                        r_st     <= n_st;
                        r_len    <= n_sticky ? 16'd0 : n_off;
                        r_err    <= n_sticky;
                        r_cnt    <= n_cnt;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovld || o_out.ready) begin
                        r_ovld  <= 1'b1;
                        r_obyte <= (r_nb == 4'd0) ? 8'd0 : (r_idx == 4'd0) ? r_hb : r_arg[63:56];
                        r_obv   <= (r_nb != 4'd0);
                        r_olast <= (r_nb == 4'd0) || (r_idx + 4'd1 == r_nb);
                        r_ost   <= r_st;
                        r_olen  <= r_len;
                        r_oerr  <= r_err;
                        r_idx   <= r_idx + 4'd1;
                        if (r_idx != 4'd0) begin
                            r_arg <= {r_arg[55:0], 8'd0};
                        end
                        if ((r_nb == 4'd0) || (r_idx + 4'd1 == r_nb)) begin
                            r_state <= r_cnt ? S_WRD : S_IDLE;
                        end
                    end
                end
                S_WRD: begin
                    r_state <= (r_depth == '0) ? S_IDLE : S_WCHK;
                end
                S_WCHK: begin
                    // frame full: pop and count it in the parent
                    if (done1 < r_rdata.count) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_depth <= r_depth - 1'b1;
                        r_state <= (r_depth == DW'(1)) ? S_IDLE : S_WRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ovld;
    assign o_out.out_byte       = r_obyte;
    assign o_out.byte_valid     = r_obv;
    assign o_out.last           = r_olast;
    assign o_out.status         = r_ost;
    assign o_out.encoded_length = r_olen;
    assign o_out.error_flag     = r_oerr;

    `CDE_ASSERT_NOW(a_nobyte_last, i_clk, i_rst_n, o_out.valid && !o_out.byte_valid, o_out.last)
    `CDE_ASSERT_NOW(a_err_len, i_clk, i_rst_n, o_out.valid && o_out.error_flag, o_out.encoded_length == 16'd0)
    `CDE_ASSERT_NOW(a_depth_max, i_clk, i_rst_n, 1'b1, r_depth <= DW'(MAX_NEST))
    `CDE_ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, acc, r_state == S_EMIT)

endmodule

// ===== test/cde_checker.sv =====
`timescale 1ns / 100ps

module cde_checker
    import cde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    cde_in_if           in_ch,
    cde_out_if          out_ch,
    output int          o_fail_count,
    output int          o_words_due
);

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        t_status     status;
        logic [15:0] encoded_length;
        logic        error_flag;
    } t_word;

    t_word       words_due_q[$];
    logic [15:0] capacity;
    logic [15:0] offset;
    logic        sticky;
    int unsigned depth;
    logic [63:0] frame_count[C_MAX_NEST];
    logic [63:0] frame_done[C_MAX_NEST];
    logic [63:0] str_left;
    logic [7:0]  emitted[9];
    int unsigned n_emitted;

    // data is left-aligned; returns 1 when the chunk is refused
    function automatic logic put_chunk(input logic [63:0] data, input int unsigned len);
        if (sticky) return 1'b1;
        if (32'(offset) + len > 32'(capacity)) begin
            sticky = 1'b1;
            return 1'b1;
        end
        for (int unsigned i = 0; i < len; i++) emitted[n_emitted + i] = data[63 - 8 * i -: 8];
        n_emitted += len;
        offset = offset + 16'(len);
        return 1'b0;
    endfunction

    function automatic logic put_head(input logic [2:0] maj, input logic [63:0] v);
        logic [4:0]  ai;
        int unsigned nb;
        if (v <= 64'd23) return put_chunk({maj, v[4:0], 56'd0}, 1);
        if (v <= 64'hFF) begin
            ai = AI_ONE; nb = 1;
        end else if (v <= 64'hFFFF) begin
            ai = AI_TWO; nb = 2;
        end else if (v <= 64'hFFFF_FFFF) begin
            ai = AI_FOUR; nb = 4;
        end else begin
            ai = AI_EIGHT; nb = 8;
        end
        if (put_chunk({maj, ai, 56'd0}, 1)) return 1'b1;
        return put_chunk(v << (64 - 8 * nb), nb);
    endfunction

    // count one finished item and pop every frame it completes
    function automatic void count_item();
        if (depth == 0) return;
        frame_done[depth - 1]++;
        while (depth > 0) begin
            if (frame_done[depth - 1] < frame_count[depth - 1]) break;
            depth--;
            if (depth > 0) frame_done[depth - 1]++;
        end
    endfunction

    function automatic t_status open_container(input logic [2:0] maj, input logic [63:0] cnt);
        logic [63:0] items;
        items = cnt;
        if (depth >= C_MAX_NEST) begin
            sticky = 1'b1;
            return ST_NESTING;
        end
        if (maj == MAJ_MAP) begin
            if (cnt[63]) begin
                sticky = 1'b1;
                return ST_NESTING;
            end
            items = cnt << 1;
        end
        if (put_head(maj, cnt)) return ST_OVERFLOW;
        if (cnt == 0) begin
            count_item();
            return ST_OK;
        end
        frame_count[depth] = items;
        frame_done[depth] = 64'd0;
        depth++;
        return ST_OK;
    endfunction

    function automatic t_status simple_item(input logic [63:0] v);
        if (put_head(MAJ_SIMPLE, v)) return ST_OVERFLOW;
        count_item();
        return ST_OK;
    endfunction

    function automatic t_status scalar_done(input logic fail);
        if (fail) return ST_OVERFLOW;
        count_item();
        return ST_OK;
    endfunction

    function automatic void predict_words(input t_opcode op, input logic [63:0] v,
                                          input logic [7:0] pb);
        t_status     st;
        t_word       w;
        int unsigned nres;
        st = ST_OK;
        n_emitted = 0;
        if (str_left != 0 && op != OP_START && op != OP_PAYLD) begin
            st = ST_INVALID;
        end else begin
            case (op)
                OP_START: begin
                    offset = '0; sticky = 1'b0; depth = 0; str_left = '0;
                end
                OP_UINT:   st = scalar_done(put_head(MAJ_UINT, v));
                OP_NEGINT: st = scalar_done(put_head(MAJ_NEGINT, v));
                OP_INT:    st = scalar_done(v[63] ? put_head(MAJ_NEGINT, ~v)
                                                  : put_head(MAJ_UINT, v));
                OP_BSTR, OP_TSTR: begin
                    if (put_head(op == OP_BSTR ? MAJ_BSTR : MAJ_TSTR, v)) st = ST_OVERFLOW;
                    else if (v == 0) count_item();
                    else str_left = v;
                end
                OP_PAYLD: begin
                    if (str_left == 0) st = ST_INVALID;
                    else if (put_chunk({pb, 56'd0}, 1)) st = ST_OVERFLOW;
                    else begin
                        str_left--;
                        if (str_left == 0) count_item();
                    end
                end
                OP_ARRAY:  st = open_container(MAJ_ARRAY, v);
                OP_MAP:    st = open_container(MAJ_MAP, v);
                OP_TAG:    st = put_head(MAJ_TAG, v) ? ST_OVERFLOW : ST_OK;
                OP_BOOL:   st = simple_item(v != 0 ? SV_TRUE : SV_FALSE);
                OP_NULL:   st = simple_item(SV_NULL);
                OP_UNDEF:  st = simple_item(SV_UNDEF);
                OP_SIMPLE: begin
                    if ((v >= 64'd24 && v <= 64'd31) || v > 64'hFF) st = ST_INVALID;
                    else st = simple_item(v);
                end
                OP_FLOAT: begin
                    if (put_chunk({HB_FLOAT, 56'd0}, 1)) st = ST_OVERFLOW;
                    else st = scalar_done(put_chunk({v[31:0], 32'd0}, 4));
                end
                default: begin
                    if (put_chunk({HB_DOUBLE, 56'd0}, 1)) st = ST_OVERFLOW;
                    else st = scalar_done(put_chunk(v, 8));
                end
            endcase
        end
        nres = (n_emitted != 0) ? n_emitted : 1;
        for (int unsigned i = 0; i < nres; i++) begin
            w.out_byte       = (n_emitted != 0) ? emitted[i] : 8'd0;
            w.byte_valid     = (n_emitted != 0);
            w.last           = (i + 1 == nres);
            w.status         = st;
            w.encoded_length = sticky ? 16'd0 : offset;
            w.error_flag     = sticky;
            words_due_q.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin
        t_word seen;
        t_word want;
        if (!i_rst_n) begin
            capacity = C_CAP_RESET;
            offset = '0; sticky = 1'b0; depth = 0; str_left = '0;
            words_due_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                predict_words(t_opcode'(in_ch.opcode), in_ch.value, in_ch.payload_byte);
            if (out_ch.valid && out_ch.ready) begin
                seen = '{out_ch.out_byte, out_ch.byte_valid, out_ch.last,
                         t_status'(out_ch.status), out_ch.encoded_length, out_ch.error_flag};
                if (words_due_q.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, seen);
                    o_fail_count++;
                end else begin
                    want = words_due_q.pop_front();
                    if (seen !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, seen);
                        o_fail_count++;
                    end
                end
            end
        end
        o_words_due = words_due_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cde_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    int          fail_count;
    int          words_due;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    int          words_sent = 0;
    int          quiet_cycles = 0;

    cde_in_if  in_ch ();
    cde_out_if out_ch ();

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.value = '0;
        in_ch.payload_byte = '0;
        out_ch.ready = 1'b0;
    end

    always #5 clk = ~clk;

    cbor_deterministic_encoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    cde_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    // receiver: hold off while a long stall is requested, else stall at random
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready = 1'b0;
            hold_cycles--;
        end else begin
            out_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_word(input t_opcode op, input logic [63:0] v, input logic [7:0] pb);
        if ($urandom_range(99) < idle_pct) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_ch.opcode = op;
        in_ch.value = v;
        in_ch.payload_byte = pb;
        in_ch.valid = 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (words_due != 0) @(negedge clk);
        // allow the container walk to finish
        repeat (40) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        cfg_wdata = cap;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(4))
            0: return 64'($urandom_range(23));
            1: return 64'($urandom_range(255, 24));
            2: return 64'($urandom_range(65535, 256));
            3: return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic gen_item(input int lvl);
        int          r;
        int          cnt;
        t_opcode     op;
        logic [63:0] v;
        r = (lvl >= 9) ? 99 : $urandom_range(99);
        if (r < 12) begin
            cnt = (lvl < 3) ? $urandom_range(3) : $urandom_range(1);
            send_word(OP_ARRAY, 64'(cnt), 8'($urandom));
            repeat (cnt) gen_item(lvl + 1);
        end else if (r < 20) begin
            cnt = (lvl < 3) ? $urandom_range(2) : $urandom_range(1);
            send_word(OP_MAP, 64'(cnt), 8'($urandom));
            repeat (2 * cnt) gen_item(lvl + 1);
        end else if (r < 32) begin
            cnt = $urandom_range(4);
            send_word($urandom_range(1) ? OP_BSTR : OP_TSTR, 64'(cnt), 8'($urandom));
            repeat (cnt) send_word(OP_PAYLD, {$urandom, $urandom}, 8'($urandom));
        end else if (r < 37) begin
            send_word(OP_TAG, rand_value(), 8'($urandom));
            gen_item(lvl + 1);
        end else if (r < 45) begin
            // noise: any opcode with any argument
            send_word(t_opcode'($urandom_range(15)), rand_value(), 8'($urandom));
        end else begin
            case ($urandom_range(8))
                0: op = OP_UINT;
                1: op = OP_NEGINT;
                2: op = OP_INT;
                3: op = OP_BOOL;
                4: op = OP_NULL;
                5: op = OP_UNDEF;
                6: op = OP_SIMPLE;
                7: op = OP_FLOAT;
                default: op = OP_DOUBLE;
            endcase
            v = rand_value();
            if (op == OP_SIMPLE && $urandom_range(3) != 0) v = 64'($urandom_range(40));
            if (op == OP_INT || op == OP_FLOAT || op == OP_DOUBLE) v = {$urandom, $urandom};
            send_word(op, v, 8'($urandom));
        end
    endtask

    task automatic gen_document();
        send_word(OP_START, rand_value(), 8'($urandom));
        if ($urandom_range(9) == 0) begin
            // deep chain of single-item arrays, sometimes past the limit
            repeat ($urandom_range(9, 6)) send_word(OP_ARRAY, 64'd1, 8'($urandom));
        end
        repeat ($urandom_range(3, 1)) gen_item(0);
    endtask

    task automatic run_phase(input int s_idle, input int r_stall, input int n_words,
                             input logic [15:0] cap, input logic pressure);
        int target;
        drain();
        write_capacity(cap);
        idle_pct = s_idle;
        stall_pct = r_stall;
        target = words_sent + n_words;
        if (pressure) begin
            @(posedge clk);
            hold_cycles = 300;
            @(negedge clk);
        end
        while (words_sent < target) gen_document();
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        send_word(OP_START, '0, 8'h00);
        send_word(OP_UINT, 64'd0, 8'h00);
        send_word(OP_UINT, 64'd23, 8'h00);
        send_word(OP_UINT, 64'd24, 8'h00);
        send_word(OP_UINT, '1, 8'h00);
        send_word(OP_NEGINT, 64'h100, 8'h00);
        send_word(OP_INT, '1, 8'h00);
        send_word(OP_INT, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
        send_word(OP_BSTR, 64'd0, 8'h00);
        send_word(OP_TSTR, 64'd2, 8'h00);
        send_word(OP_UINT, 64'd5, 8'h00);
        send_word(OP_PAYLD, '0, 8'h00);
        send_word(OP_PAYLD, '1, 8'hFF);
        send_word(OP_PAYLD, '0, 8'h5A);
        send_word(OP_ARRAY, 64'd0, 8'h00);
        send_word(OP_SIMPLE, 64'd24, 8'h00);
        send_word(OP_SIMPLE, 64'd256, 8'h00);
        send_word(OP_SIMPLE, 64'd255, 8'h00);
        send_word(OP_BOOL, 64'd1, 8'h00);
        send_word(OP_BOOL, 64'd0, 8'h00);
        send_word(OP_NULL, '0, 8'h00);
        send_word(OP_UNDEF, '0, 8'h00);
        send_word(OP_TAG, 64'h1_0000, 8'h00);
        send_word(OP_FLOAT, 64'h1234_5678_3F80_0000, 8'h00);
        send_word(OP_DOUBLE, 64'h3FF0_0000_0000_0001, 8'h00);
        send_word(OP_MAP, 64'h8000_0000_0000_0000, 8'h00);
        send_word(OP_START, '0, 8'h00);
        repeat (9) send_word(OP_ARRAY, 64'd1, 8'h00);

        run_phase(0, 0, 90, 16'hFFFF, 1'b1);
        run_phase(46, 0, 90, 16'd40, 1'b0);
        run_phase(0, 46, 70, 16'd0, 1'b0);
        run_phase(0, 46, 40, 16'd12, 1'b0);
        run_phase(17, 17, 80, 16'($urandom_range(200, 1)), 1'b0);
        run_phase(0, 0, 40, C_CAP_RESET, 1'b0);
        drain();

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cde_pkg.sv
hw/rtl/cde_if.sv
hw/rtl/cbor_deterministic_encoder_core.sv
test/cde_checker.sv
test/tb_top.sv
